### hdl/sme_pkg.sv
// shared definitions for the stack machine executor
// opcodes, status and output kind codes, controller states and default sizes
// no dependencies
package sme_pkg;

    localparam int unsigned DEFAULT_STACK_DEPTH = 128;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned IMM_W = 24;
    localparam int unsigned OP_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned DIV_STEPS = 32;

    localparam logic [OP_W-1:0] OP_HALT  = 8'd0;
    localparam logic [OP_W-1:0] OP_PUSHC = 8'd1;
    localparam logic [OP_W-1:0] OP_ADD   = 8'd2;
    localparam logic [OP_W-1:0] OP_SUB   = 8'd3;
    localparam logic [OP_W-1:0] OP_MUL   = 8'd4;
    localparam logic [OP_W-1:0] OP_DIV   = 8'd5;
    localparam logic [OP_W-1:0] OP_MOD   = 8'd6;
    localparam logic [OP_W-1:0] OP_RDINT = 8'd7;
    localparam logic [OP_W-1:0] OP_WRINT = 8'd8;
    localparam logic [OP_W-1:0] OP_RDCHR = 8'd9;
    localparam logic [OP_W-1:0] OP_WRCHR = 8'd10;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_HALT  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDER = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVER  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_DIV0  = 3'd4;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

### hdl/stack_machine_executor.sv
// stack machine executor: operand stack in one memory, 32-bit alu and serial divider; uses sme_pkg
// results go to the output register from ST_EXEC or ST_DIV, or from ST_DONE if the output was full
// an instruction is taken only in ST_IDLE (stack read), then executed and written back; div and
//   mod go on in ST_DIV, a one-bit-per-cycle restoring divider, then a sign fixup
// a pending result waits in the output register while the next instruction is taken
// reset (aresetn low, synchronous): stack empty, halted flag clear, output empty; memory kept
module stack_machine_executor #(
    parameter int unsigned STACK_DEPTH = sme_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [23:0] imm_value, [55:24] read_value
    input  logic [55:0] s_tdata,
    // s_tuser: [7:0] op_code
    input  logic [7:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [31:0] write_value, [34:32] exec_status, [39:35] zero
    output logic [39:0] m_tdata,
    // m_tuser: [1:0] write_kind
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
    localparam int unsigned W = sme_pkg::WORD_W;
    localparam int unsigned DCNT_W = $clog2(sme_pkg::DIV_STEPS + 1);

    sme_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] sp_reg, sp_next;
    logic             halted_reg, halted_next;

    logic [sme_pkg::OP_W-1:0]  op_reg;
    logic [sme_pkg::IMM_W-1:0] imm_reg;
    logic [W-1:0]              rdval_reg;

    // stack memory, two registered read ports, one write port
    logic [W-1:0]     stack_mem [STACK_DEPTH];
    logic [W-1:0]     rd_top_q, rd_sec_q;
    logic [IDX_W-1:0] raddr_top, raddr_sec;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [W-1:0]     mem_wdata;

    // divider
    logic [W-1:0]      dvsr_reg, dvsr_next;
    logic [W-1:0]      quo_reg, quo_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [W:0]        trial;
    logic              div_go;
    logic              div_done;

    // finished result of this cycle and the parked copy
    logic                         fin_valid;
    logic [W-1:0]                 fin_value;
    logic [sme_pkg::KIND_W-1:0]   fin_kind;
    logic [sme_pkg::STATUS_W-1:0] fin_status;
    logic [W-1:0]                 res_value_reg;
    logic [sme_pkg::KIND_W-1:0]   res_kind_reg;
    logic [sme_pkg::STATUS_W-1:0] res_status_reg;

    // output register
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [W-1:0]                 out_value_reg;
    logic [sme_pkg::KIND_W-1:0]   out_kind_reg;
    logic [sme_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_free;
    logic                         out_load;

    logic             in_fire;
    logic [CNT_W-1:0] sp_m1, sp_m2;
    logic [W-1:0]     alu_a, alu_b;
    logic [W-1:0]     quo_fix, rem_fix;

    assign s_tready = (state_reg == sme_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign sp_m1     = sp_reg - CNT_W'(1);
    assign sp_m2     = sp_reg - CNT_W'(2);
    assign raddr_top = sp_m1[IDX_W-1:0];
    assign raddr_sec = sp_m2[IDX_W-1:0];
    assign alu_b     = rd_top_q;
    assign alu_a     = rd_sec_q;

    assign trial    = {rem_reg, quo_reg[W-1]} - {1'b0, dvsr_reg};
    assign div_done = (dcnt_reg == DCNT_W'(sme_pkg::DIV_STEPS));
    assign quo_fix  = neg_q_reg ? (~quo_reg + W'(1)) : quo_reg;
    assign rem_fix  = neg_r_reg ? (~rem_reg + W'(1)) : rem_reg;

    // reads happen every cycle; a write-back lands before the next instruction's read, as ST_IDLE
    // lies between them, so no forwarding path is needed
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_top_q <= stack_mem[raddr_top];
        rd_sec_q <= stack_mem[raddr_sec];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sme_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = sme_pkg::ST_EXEC;
                end
            end
            sme_pkg::ST_EXEC: begin
                if (div_go) begin
                    state_next = sme_pkg::ST_DIV;
                end else begin
                    state_next = out_free ? sme_pkg::ST_IDLE : sme_pkg::ST_DONE;
                end
            end
            sme_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = out_free ? sme_pkg::ST_IDLE : sme_pkg::ST_DONE;
                end
            end
            sme_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = sme_pkg::ST_IDLE;
                end
            end
            default: state_next = sme_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        sp_next     = sp_reg;
        halted_next = halted_reg;
        mem_we      = 1'b0;
        mem_waddr   = sp_reg[IDX_W-1:0];
        mem_wdata   = '0;
        div_go      = 1'b0;
        fin_valid   = 1'b0;
        fin_value   = '0;
        fin_kind    = sme_pkg::KIND_NONE;
        fin_status  = sme_pkg::STATUS_OK;
        dvsr_next   = dvsr_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        dcnt_next   = dcnt_reg;

        case (state_reg)
            sme_pkg::ST_EXEC: begin
                fin_valid = 1'b1;
                if (halted_reg) begin
                    fin_status = sme_pkg::STATUS_HALT;
                end else begin
                    case (op_reg)
                        sme_pkg::OP_HALT: begin
                            halted_next = 1'b1;
                            fin_status  = sme_pkg::STATUS_HALT;
                        end
                        sme_pkg::OP_PUSHC, sme_pkg::OP_RDINT, sme_pkg::OP_RDCHR: begin
                            if (sp_reg == CNT_W'(STACK_DEPTH)) begin
                                fin_status = sme_pkg::STATUS_OVER;
                            end else begin
                                mem_we  = 1'b1;
                                sp_next = sp_reg + CNT_W'(1);
                                if (op_reg == sme_pkg::OP_PUSHC) begin
                                    mem_wdata = {{(W - sme_pkg::IMM_W){imm_reg[sme_pkg::IMM_W-1]}},
                                                 imm_reg};
                                end else if (op_reg == sme_pkg::OP_RDCHR) begin
                                    mem_wdata = {{(W - 8){rdval_reg[7]}}, rdval_reg[7:0]};
                                end else begin
                                    mem_wdata = rdval_reg;
                                end
                            end
                        end
                        sme_pkg::OP_WRINT, sme_pkg::OP_WRCHR: begin
                            if (sp_reg == '0) begin
                                fin_status = sme_pkg::STATUS_UNDER;
                            end else begin
                                sp_next = sp_m1;
                                if (op_reg == sme_pkg::OP_WRINT) begin
                                    fin_value = alu_b;
                                    fin_kind  = sme_pkg::KIND_INT;
                                end else begin
                                    fin_value = {{(W - 8){1'b0}}, alu_b[7:0]};
                                    fin_kind  = sme_pkg::KIND_CHR;
                                end
                            end
                        end
                        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL: begin
                            if (sp_reg < CNT_W'(2)) begin
                                fin_status = sme_pkg::STATUS_UNDER;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = sp_m2[IDX_W-1:0];
                                sp_next   = sp_m1;
                                if (op_reg == sme_pkg::OP_ADD) begin
                                    mem_wdata = alu_a + alu_b;
                                end else if (op_reg == sme_pkg::OP_SUB) begin
                                    mem_wdata = alu_a - alu_b;
                                end else begin
                                    mem_wdata = alu_a * alu_b;
                                end
                            end
                        end
                        sme_pkg::OP_DIV, sme_pkg::OP_MOD: begin
                            if (sp_reg < CNT_W'(2)) begin
                                fin_status = sme_pkg::STATUS_UNDER;
                            end else if (alu_b == '0) begin
                                fin_status = sme_pkg::STATUS_DIV0;
                            end else begin
                                // divide magnitudes, fix signs at the end
                                fin_valid  = 1'b0;
                                div_go     = 1'b1;
                                dvsr_next  = alu_b[W-1] ? (~alu_b + W'(1)) : alu_b;
                                quo_next   = alu_a[W-1] ? (~alu_a + W'(1)) : alu_a;
                                rem_next   = '0;
                                neg_q_next = alu_a[W-1] ^ alu_b[W-1];
                                neg_r_next = alu_a[W-1];
                                dcnt_next  = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sme_pkg::ST_DIV: begin
                if (div_done) begin
                    fin_valid = 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = sp_m2[IDX_W-1:0];
                    sp_next   = sp_m1;
                    mem_wdata = (op_reg == sme_pkg::OP_DIV) ? quo_fix : rem_fix;
                end else begin
                    dcnt_next = dcnt_reg + DCNT_W'(1);
                    if (!trial[W]) begin
                        rem_next = trial[W-1:0];
                        quo_next = {quo_reg[W-2:0], 1'b1};
                    end else begin
                        rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                        quo_next = {quo_reg[W-2:0], 1'b0};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign out_load = out_free && (fin_valid || (state_reg == sme_pkg::ST_DONE));
    assign m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sme_pkg::ST_IDLE;
            sp_reg       <= '0;
            halted_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            dcnt_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            sp_reg       <= sp_next;
            halted_reg   <= halted_next;
            m_tvalid_reg <= m_tvalid_next;
            dcnt_reg     <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg    <= s_tuser;
            imm_reg   <= s_tdata[23:0];
            rdval_reg <= s_tdata[55:24];
        end
        dvsr_reg  <= dvsr_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        if (fin_valid) begin
            res_value_reg  <= fin_value;
            res_kind_reg   <= fin_kind;
            res_status_reg <= fin_status;
        end
        if (out_load) begin
            if (state_reg == sme_pkg::ST_DONE) begin
                out_value_reg  <= res_value_reg;
                out_kind_reg   <= res_kind_reg;
                out_status_reg <= res_status_reg;
            end else begin
                out_value_reg  <= fin_value;
                out_kind_reg   <= fin_kind;
                out_status_reg <= fin_status;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_status_reg, out_value_reg};
    assign m_tuser  = out_kind_reg;

endmodule

### hdl/sme_checker.sv
// port-level checks for stack_machine_executor, attached by bind
// depends on sme_pkg
module sme_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tvalid,
    input logic        m_tready
);

    logic halt_seen_reg;
    logic m_fire;

    assign m_fire = m_tvalid && m_tready;

    // remembers a delivered halted status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_seen_reg <= 1'b0;
        end else if (m_fire && (m_tdata[34:32] == sme_pkg::STATUS_HALT)) begin
            halt_seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_seen_reg && m_tvalid |-> m_tdata[34:32] == sme_pkg::STATUS_HALT)
        else $error("result after halt is not halted");

    a_emit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != sme_pkg::KIND_NONE) |-> m_tdata[34:32] == sme_pkg::STATUS_OK)
        else $error("write output with error status");

    a_no_emit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == sme_pkg::KIND_NONE) |-> m_tdata[31:0] == 32'd0)
        else $error("nonzero value without write");

    a_chr_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == sme_pkg::KIND_CHR) |-> m_tdata[31:8] == 24'd0)
        else $error("character output wider than a byte");

endmodule

bind stack_machine_executor sme_checker u_sme_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
